// ----- hw/rtl/tlc_pkg.sv -----
`timescale 1ns / 1ps
package tlc_pkg;
    localparam logic [1:0] KIND_IFETCH = 2'd0;
    localparam logic [1:0] KIND_DREAD  = 2'd1;
    localparam logic [1:0] KIND_DWRITE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INDEX  = 2'd1;
    localparam logic [1:0] REG_WAYS   = 2'd2;

    typedef struct packed {
        logic l1_hit;
        logic l2_accessed;
        logic l2_hit;
        logic l2_writeback;
        logic [3:0] l2_way;
    } result_t;
endpackage

// ----- hw/rtl/two_level_cache_lru_model.sv -----
`timescale 1ns / 1ps
// channel   | signals                                   | beat
// ----------+-------------------------------------------+--------------------------
// access in | in_valid in_ready kind address            | one access
// result    | out_valid out_ready l1_hit .. l2_way      | one result per access
// config    | psel penable pwrite paddr pwdata prdata   | apb register write/read
//
// the accepting edge reads the l1 lines and the l2 set into registers (sync memories);
// the next cycle does the lookup, writes the set back and loads the result register,
// and sets the result valid flag, so the result beat is registered.
// the input waits while a result is held, so the next access is taken only once the
// last result has been taken; an output stall holds it off until out_ready.
// the l2 set is one wide memory word holding every way, valid bits included.
// after reset a clearing pass over max(L1_SETS, L2_MAX_SETS) entries (256 by default)
// writes the reset contents into all three memories; the input is held off meanwhile.
module two_level_cache_lru_model
    import tlc_pkg::*;
#(
    parameter int L1_SETS       = 256,
    parameter int L1_LINE_BYTES = 64,
    parameter int L2_MAX_SETS   = 256,
    parameter int L2_MAX_WAYS   = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [63:0] address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        l1_hit,
    output logic        l2_accessed,
    output logic        l2_hit,
    output logic        l2_writeback,
    output logic [3:0]  l2_way,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int L1_OFF = $clog2(L1_LINE_BYTES);
    localparam int L1_IB  = $clog2(L1_SETS);
    localparam int L1_TW  = 64 - L1_OFF - L1_IB;
    localparam int L2_IBM = $clog2(L2_MAX_SETS);
    localparam int L2_SW  = (L2_IBM > 0) ? L2_IBM : 1;
    localparam int L2_WW  = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
    localparam int L2_RW  = $clog2(L2_MAX_WAYS + 1);
    localparam int L2_TW  = 62;
    localparam int ENT_W  = L2_TW + 2 + L2_RW;
    localparam int CLR_N  = (L1_SETS > L2_MAX_SETS) ? L1_SETS : L2_MAX_SETS;
    localparam int CLR_W  = $clog2(CLR_N);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] off_reg, ib_reg;
    logic [4:0] ways_reg;

    logic [1:0]  kind_reg;
    logic [63:0] addr_reg;
    result_t     res_reg;
    logic        out_valid_reg;

    // clearing pass after reset
    logic [CLR_W-1:0] clr_reg;
    logic             clr_busy_reg;

    // config
    logic [1:0] reg_sel;
    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;
    always_comb
    begin
        unique case (reg_sel)
            REG_OFFSET: prdata = {28'd0, off_reg};
            REG_INDEX:  prdata = {28'd0, ib_reg};
            REG_WAYS:   prdata = {27'd0, ways_reg};
            default:    prdata = 32'd0;
        endcase
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= 4'd6;
            ib_reg   <= 4'd5;
            ways_reg <= 5'd4;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_OFFSET: off_reg  <= pwdata[3:0];
                REG_INDEX:  ib_reg   <= pwdata[3:0];
                REG_WAYS:   ways_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // effective config
    logic [3:0] off_e, ib_e;
    logic [L2_RW-1:0] ways_e;
    always_comb
    begin
        off_e = (off_reg < 4'd2) ? 4'd2 : ((off_reg > 4'd10) ? 4'd10 : off_reg);
        ib_e  = (ib_reg > 4'(L2_IBM)) ? 4'(L2_IBM) : ib_reg;
        if (ways_reg == 5'd0)
            ways_e = L2_RW'(1);
        else if (32'(ways_reg) > L2_MAX_WAYS)
            ways_e = L2_RW'(L2_MAX_WAYS);
        else
            ways_e = L2_RW'(ways_reg);
    end

    // address split of the incoming access
    logic [L1_IB-1:0] idx_in, idx_reg;
    logic [L2_SW-1:0] set_in, set_reg;
    logic [63:0] setmask;
    assign idx_in  = address[L1_OFF +: L1_IB];
    assign setmask = (64'd1 << ib_e) - 64'd1;
    always_comb
    begin
        logic [63:0] sh;
        sh = (address >> off_e) & setmask;
        set_in = sh[L2_SW-1:0];
    end

    logic accept;
    assign in_ready = !clr_busy_reg && (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_reg <= clr_reg + CLR_W'(1);
            if (clr_reg == CLR_W'(CLR_N - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // l1 stores: icache word {valid, tag}, dcache word {valid, dirty, tag}
    logic [L1_TW:0]   itag_mem [L1_SETS];
    logic [L1_TW+1:0] dtag_mem [L1_SETS];
    logic [L1_TW:0]   itag_q;
    logic [L1_TW+1:0] dtag_q;

    // l2 set memory, one word per set holding all ways
    logic [L2_MAX_WAYS*ENT_W-1:0] l2_mem [L2_MAX_SETS];
    logic [L2_MAX_WAYS*ENT_W-1:0] l2_q, l2_wdata, l2_rst_word;
    logic l2_we, i_we, d_we;

    // reset contents of one set: tags all ones, invalid, clean, rank equal to way
    always_comb
    begin
        for (int w = 0; w < L2_MAX_WAYS; w++)
            l2_rst_word[w*ENT_W +: ENT_W] = {{L2_TW{1'b1}}, 1'b0, 1'b0, L2_RW'(w)};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            itag_q <= itag_mem[idx_in];
            dtag_q <= dtag_mem[idx_in];
            l2_q   <= l2_mem[set_in];
        end
        if (clr_busy_reg)
        begin
            itag_mem[clr_reg[L1_IB-1:0]] <= {1'b0, {L1_TW{1'b1}}};
            dtag_mem[clr_reg[L1_IB-1:0]] <= {2'b00, {L1_TW{1'b1}}};
            l2_mem[clr_reg[L2_SW-1:0]]   <= l2_rst_word;
        end
        else
        begin
            if (i_we)
                itag_mem[idx_reg] <= {1'b1, addr_reg[63 -: L1_TW]};
            if (d_we)
                dtag_mem[idx_reg] <= {1'b1, wr, addr_reg[63 -: L1_TW]};
            if (l2_we)
                l2_mem[set_reg] <= l2_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            addr_reg <= address;
            idx_reg  <= idx_in;
            set_reg  <= set_in;
        end
    end

    // lookup
    logic [L2_TW-1:0] tag2;
    logic l1h, acc, hit, wb, wr;
    logic [L2_WW-1:0] pos;
    always_comb
    begin
        logic [63:0] t;
        logic [L2_TW-1:0] et [L2_MAX_WAYS];
        logic ev [L2_MAX_WAYS];
        logic ed [L2_MAX_WAYS];
        logic [L2_RW-1:0] er [L2_MAX_WAYS];
        logic [L2_RW-1:0] old;
        logic found, got0;
        // shift amount up to 18 needs five bits
        t = addr_reg >> ({1'b0, off_e} + {1'b0, ib_e});
        tag2 = t[L2_TW-1:0];
        wr = (kind_reg == KIND_DWRITE);
        for (int w = 0; w < L2_MAX_WAYS; w++)
        begin
            et[w] = l2_q[w*ENT_W + L2_RW + 2 +: L2_TW];
            ev[w] = l2_q[w*ENT_W + L2_RW + 1];
            ed[w] = l2_q[w*ENT_W + L2_RW];
            er[w] = l2_q[w*ENT_W +: L2_RW];
        end
        l1h = 1'b0;
        i_we = 1'b0;
        d_we = 1'b0;
        unique case (kind_reg)
            KIND_IFETCH: l1h = itag_q[L1_TW] && (itag_q[L1_TW-1:0] == addr_reg[63 -: L1_TW]);
            KIND_DREAD, KIND_DWRITE:
                l1h = dtag_q[L1_TW+1] && (dtag_q[L1_TW-1:0] == addr_reg[63 -: L1_TW]);
            default: l1h = 1'b0;
        endcase
        acc = (kind_reg != KIND_UNUSED) && !l1h;
        if (state_reg == ST_LOOK)
        begin
            if (acc)
            begin
                i_we = (kind_reg == KIND_IFETCH);
                d_we = !i_we;
            end
            else if (l1h && wr)
                d_we = 1'b1;    // write hit only sets the dirty bit
        end
        found = 1'b0;
        got0 = 1'b0;
        pos = '0;
        for (int w = 0; w < L2_MAX_WAYS; w++)
            if (L2_RW'(w) < ways_e && ev[w] && et[w] == tag2)
            begin
                found = 1'b1;
                pos = L2_WW'(w);
            end
        wb = 1'b0;
        if (!found)
        begin
            for (int w = 0; w < L2_MAX_WAYS; w++)
                if (!got0 && L2_RW'(w) < ways_e && er[w] == '0)
                begin
                    got0 = 1'b1;
                    pos = L2_WW'(w);
                end
            wb = ed[pos];
            et[pos] = tag2;
            ev[pos] = 1'b1;
            ed[pos] = wr;
        end
        else if (wr)
            ed[pos] = 1'b1;
        hit = found;
        old = er[pos];
        for (int w = 0; w < L2_MAX_WAYS; w++)
            if (L2_RW'(w) < ways_e && er[w] > old)
                er[w] = er[w] - L2_RW'(1);
        er[pos] = ways_e - L2_RW'(1);
        for (int w = 0; w < L2_MAX_WAYS; w++)
            l2_wdata[w*ENT_W +: ENT_W] = {et[w], ev[w], ed[w], er[w]};
        l2_we = (state_reg == ST_LOOK) && acc;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_IDLE;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_LOOK)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK)
        begin
            res_reg.l1_hit       <= l1h;
            res_reg.l2_accessed  <= acc;
            res_reg.l2_hit       <= acc && hit;
            res_reg.l2_writeback <= acc && wb;
            res_reg.l2_way       <= acc ? 4'(pos) : 4'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign l1_hit       = res_reg.l1_hit;
    assign l2_accessed  = res_reg.l2_accessed;
    assign l2_hit       = res_reg.l2_hit;
    assign l2_writeback = res_reg.l2_writeback;
    assign l2_way       = res_reg.l2_way;
endmodule

// ----- hw/rtl/tlc_checker.sv -----
`timescale 1ns / 1ps
module tlc_checker
    import tlc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic l1_hit,
    input logic l2_accessed,
    input logic l2_hit,
    input logic l2_writeback,
    input logic [3:0] l2_way
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(l2_way))
        else $error("result dropped under stall");
    a_hitacc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (l2_hit || l2_writeback) |-> l2_accessed && !l1_hit)
        else $error("l2 flags without l2 access");
    a_way0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !l2_accessed |-> l2_way == 4'd0)
        else $error("way without access");
    a_oneout: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##1 !in_ready)
        else $error("accepted two accesses back to back");
endmodule

bind two_level_cache_lru_model tlc_checker u_tlc_checker (.*);
